### src/ioc_pkg.sv
package ioc_pkg;

    // item geometry
    localparam int AXES      = 6;
    localparam int SMP_W     = 16;   // raw reading width
    localparam int OUT_W     = 25;   // filtered output field width
    localparam int AXIS_AZ   = 2;    // accel Z lane, carries the one-g correction

    // configuration
    localparam int ALPHA_W    = 16;
    localparam int G_W        = 15;
    localparam int CFG_ADDR_W = 1;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_ADDR_W-1:0] REG_ALPHA = 1'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_G     = 1'd1;

    localparam logic [ALPHA_W-1:0] ALPHA_RESET = 16'd58982;
    localparam logic [G_W-1:0]     G_RESET     = 15'd16384;

    // stream widths
    localparam int S_TDATA_W = ((AXES * SMP_W + 7) / 8) * 8;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = ((AXES * OUT_W + 7) / 8) * 8;
    localparam int M_TUSER_W = 2;

    // s_tuser bit positions
    localparam int TU_CMD = 0;
    localparam int TU_OK  = 1;

    localparam logic CMD_MEASURE = 1'b0;
    localparam logic CMD_CAL     = 1'b1;

    // result status codes
    localparam logic [M_TUSER_W-1:0] STAT_OK       = 2'd0;
    localparam logic [M_TUSER_W-1:0] STAT_RD_FAIL  = 2'd1;
    localparam logic [M_TUSER_W-1:0] STAT_CAL      = 2'd2;
    localparam logic [M_TUSER_W-1:0] STAT_CAL_DONE = 2'd3;

    // parameter defaults
    localparam int CAL_SAMPLES_DEF = 300;
    localparam int FRAC_BITS_DEF   = 8;

endpackage

### src/ioc_filter_lane.sv
module ioc_filter_lane #(
    parameter int FRAC_BITS = ioc_pkg::FRAC_BITS_DEF
) (
    input  logic signed [ioc_pkg::SMP_W-1:0]   rd_i,
    input  logic signed [17+FRAC_BITS:0]       ofs_i,
    input  logic signed [16+FRAC_BITS:0]       filt_i,
    input  logic        [ioc_pkg::ALPHA_W-1:0] alpha_i,
    output logic signed [16+FRAC_BITS:0]       filt_o
);
    import ioc_pkg::*;

    localparam int FW    = 17 + FRAC_BITS;   // filter / sample width
    localparam int OFS_W = 18 + FRAC_BITS;
    localparam int XW    = OFS_W + 1;        // raw difference
    localparam int DW    = FW + 1;           // f - x
    localparam int PW    = DW + ALPHA_W + 1; // alpha * (f - x)
    localparam int ACC_W = PW + 1;
    localparam int QW    = ACC_W - 16;

    localparam longint LIM = longint'(65535) << FRAC_BITS;

    localparam logic signed [XW-1:0]    LIM_X = XW'(LIM);
    localparam logic signed [FW-1:0]    LIM_F = FW'(LIM);
    localparam logic signed [QW-1:0]    LIM_Q = QW'(LIM);
    localparam logic signed [ACC_W-1:0] RND   = ACC_W'(32768);

    logic signed [XW-1:0]    x_raw;
    logic signed [FW-1:0]    x_sat;
    logic signed [DW-1:0]    diff;
    logic signed [PW-1:0]    prod;
    logic signed [ACC_W-1:0] acc;
    logic signed [QW-1:0]    quo;

    // acc = alpha*f + (65536-alpha)*x  ==  (x << 16) + alpha*(f - x)
    always_comb begin
        x_raw = (XW'(rd_i) <<< FRAC_BITS) - XW'(ofs_i);
        if (x_raw > LIM_X) begin
            x_sat = LIM_F;
        end else if (x_raw < -LIM_X) begin
            x_sat = -LIM_F;
        end else begin
            x_sat = FW'(x_raw);
        end
        diff = DW'(filt_i) - DW'(x_sat);
        prod = PW'(signed'({1'b0, alpha_i})) * PW'(diff);
        acc  = (ACC_W'(x_sat) <<< 16) + ACC_W'(prod) + RND;
        quo  = QW'(acc >>> 16);
        if (quo > LIM_Q) begin
            filt_o = LIM_F;
        end else if (quo < -LIM_Q) begin
            filt_o = -LIM_F;
        end else begin
            filt_o = FW'(quo);
        end
    end

endmodule

### src/ioc_offset_div.sv
module ioc_offset_div #(
    parameter int CAL_SAMPLES = ioc_pkg::CAL_SAMPLES_DEF,
    parameter int FRAC_BITS   = ioc_pkg::FRAC_BITS_DEF
) (
    input  logic                                                    aclk,
    input  logic                                                    aresetn,
    input  logic                                                    start_i,
    input  logic signed [ioc_pkg::SMP_W+$clog2(CAL_SAMPLES+1)-1:0]  sum_i [ioc_pkg::AXES],
    input  logic        [ioc_pkg::G_W-1:0]                          g_i,
    output logic                                                    busy_o,
    output logic signed [17+FRAC_BITS:0]                            ofs_o [ioc_pkg::AXES]
);
    import ioc_pkg::*;

    localparam int CNT_W  = $clog2(CAL_SAMPLES + 1);
    localparam int SUM_W  = SMP_W + CNT_W;
    localparam int NUM_W  = SUM_W + FRAC_BITS;
    localparam int OFS_W  = 18 + FRAC_BITS;
    localparam int SH     = NUM_W + $clog2(CAL_SAMPLES);
    localparam int RCP_W  = NUM_W + 1;
    localparam int LO_W   = NUM_W / 2;
    localparam int HI_W   = NUM_W - LO_W;
    localparam int PLO_W  = LO_W + RCP_W;
    localparam int PHI_W  = HI_W + RCP_W;
    localparam int PROD_W = NUM_W + RCP_W;

    // ceil(2^SH / CAL_SAMPLES): exact floor quotient for any NUM_W-bit numerator
    localparam longint RCP_VAL = ((longint'(1) << SH) + longint'(CAL_SAMPLES) - 1)
                                 / longint'(CAL_SAMPLES);

    localparam logic [RCP_W-1:0] RCP  = RCP_W'(RCP_VAL);
    localparam logic [NUM_W-1:0] HALF = NUM_W'(CAL_SAMPLES / 2);

    logic                    busy_reg;
    logic                    prod_vld_reg;
    logic [G_W-1:0]          g_reg;
    logic                    neg_reg [AXES];
    logic [NUM_W-1:0]        num_reg [AXES];
    logic [PLO_W-1:0]        plo_reg [AXES];
    logic [PHI_W-1:0]        phi_reg [AXES];
    logic signed [OFS_W-1:0] ofs_reg [AXES];

    logic [SUM_W-1:0]        mag     [AXES];
    logic [PROD_W-1:0]       prod    [AXES];
    logic signed [OFS_W-1:0] quo_s   [AXES];
    logic signed [OFS_W-1:0] ofs_new [AXES];

    // rounded magnitude times reciprocal, split in two half-width products
    always_comb begin
        for (int i = 0; i < AXES; i++) begin
            mag[i]   = sum_i[i][SUM_W-1] ? SUM_W'(-sum_i[i]) : SUM_W'(sum_i[i]);
            prod[i]  = (PROD_W'(phi_reg[i]) << LO_W) + PROD_W'(plo_reg[i]);
            quo_s[i] = neg_reg[i] ? -OFS_W'(prod[i] >> SH) : OFS_W'(prod[i] >> SH);
            if (i == AXIS_AZ) begin
                ofs_new[i] = quo_s[i] - (OFS_W'(g_reg) <<< FRAC_BITS);
            end else begin
                ofs_new[i] = quo_s[i];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg     <= 1'b0;
            prod_vld_reg <= 1'b0;
            for (int i = 0; i < AXES; i++) begin
                ofs_reg[i] <= '0;
            end
        end else if (start_i) begin
            busy_reg     <= 1'b1;
            prod_vld_reg <= 1'b0;
        end else if (busy_reg) begin
            if (prod_vld_reg) begin
                busy_reg     <= 1'b0;
                prod_vld_reg <= 1'b0;
                for (int i = 0; i < AXES; i++) begin
                    ofs_reg[i] <= ofs_new[i];
                end
            end else begin
                prod_vld_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start_i) begin
            g_reg <= g_i;
            for (int i = 0; i < AXES; i++) begin
                neg_reg[i] <= sum_i[i][SUM_W-1];
                num_reg[i] <= (NUM_W'(mag[i]) << FRAC_BITS) + HALF;
            end
        end
        if (busy_reg && !prod_vld_reg) begin
            for (int i = 0; i < AXES; i++) begin
                plo_reg[i] <= PLO_W'(num_reg[i][LO_W-1:0]) * PLO_W'(RCP);
                phi_reg[i] <= PHI_W'(num_reg[i][NUM_W-1:LO_W]) * PHI_W'(RCP);
            end
        end
    end

    assign busy_o = busy_reg;
    assign ofs_o  = ofs_reg;

endmodule

### src/imu_offset_calibrate_lowpass.sv
// Six-axis IMU offset calibration and first-order low-pass filter. Each input
// beat carries one accel/gyro reading (signed 16-bit counts) plus a command and
// a read-ok flag in s_tuser; every beat yields exactly one result beat with a
// status in m_tuser and the six filter values (counts, FRAC_BITS fraction bits,
// low 25 bits) in m_tdata. Measure beats take offsets off the reading and run
// f = (alpha*f + (65536-alpha)*x) / 65536 per axis; a failed measure leaves
// all state alone. Calibration beats accumulate per-axis sums (a failed read
// reuses the last good reading); the CAL_SAMPLES-th beat ends the run with
// status 3. Throughput: one beat per clock while the result side accepts and
// the offset divider is idle, with an input register and an output register
// between the two sides, so a stalled result stops intake only once the
// input register is full as well. Exception: after the beat that ends a
// calibration run, processing pauses while the six new offsets are formed
// by a reciprocal multiply (split products first, then sum, sign and one-g
// correction).
module imu_offset_calibrate_lowpass #(
    parameter int CAL_SAMPLES = ioc_pkg::CAL_SAMPLES_DEF,
    parameter int FRAC_BITS   = ioc_pkg::FRAC_BITS_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    // input stream
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // accel_x, accel_y, accel_z, gyro_x, gyro_y, gyro_z (16 bits each)
    input  logic [ioc_pkg::S_TDATA_W-1:0]      s_tdata,
    // cmd, read_ok
    input  logic [ioc_pkg::S_TUSER_W-1:0]      s_tuser,
    // result stream
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // filt_accel_x, filt_accel_y, filt_accel_z, filt_gyro_x, filt_gyro_y,
    // filt_gyro_z (25 bits each), zero pad
    output logic [ioc_pkg::M_TDATA_W-1:0]      m_tdata,
    // status
    output logic [ioc_pkg::M_TUSER_W-1:0]      m_tuser,
    // configuration write port
    input  logic                               cfg_wr_en,
    input  logic [ioc_pkg::CFG_ADDR_W-1:0]     cfg_addr,
    input  logic [ioc_pkg::CFG_DATA_W-1:0]     cfg_wr_data
);
    import ioc_pkg::*;

    localparam int FW    = 17 + FRAC_BITS;           // filter state width
    localparam int OFS_W = 18 + FRAC_BITS;           // offset width
    localparam int CNT_W = $clog2(CAL_SAMPLES + 1);  // sample counter
    localparam int SUM_W = SMP_W + CNT_W;            // calibration sums

    localparam logic [CNT_W-1:0] CNT_END = CNT_W'(CAL_SAMPLES);

    // config registers
    logic [ALPHA_W-1:0] alpha_reg;
    logic [G_W-1:0]     g_reg;

    // handshake / pipeline regs
    logic                 in_valid_reg;
    logic [S_TDATA_W-1:0] in_data_reg;
    logic [S_TUSER_W-1:0] in_user_reg;
    logic                 out_valid_reg;
    logic [M_TDATA_W-1:0] out_data_reg;
    logic [M_TUSER_W-1:0] out_user_reg;

    // block state
    logic signed [FW-1:0]    filt_reg [AXES];
    logic signed [SUM_W-1:0] sum_reg  [AXES];
    logic signed [SMP_W-1:0] last_reg [AXES];
    logic [CNT_W-1:0]        cnt_reg;

    logic                    advance;
    logic                    fire;
    logic                    div_busy;
    logic                    is_cal;
    logic                    rd_ok;
    logic                    do_filter;
    logic [CNT_W-1:0]        cnt_inc;
    logic                    run_end;
    logic                    div_start;
    logic [M_TUSER_W-1:0]    status_next;
    logic [M_TDATA_W-1:0]    out_data_next;

    logic signed [SMP_W-1:0] rd        [AXES];
    logic signed [SUM_W-1:0] sum_add   [AXES];
    logic signed [FW-1:0]    lane_filt [AXES];
    logic signed [FW-1:0]    filt_next [AXES];
    logic signed [OFS_W-1:0] ofs       [AXES];

    // output stage frees up when empty or being drained; the item in the input
    // register is processed unless the offset divider is still running
    assign advance  = !out_valid_reg || m_tready;
    assign fire     = in_valid_reg && advance && !div_busy;
    assign s_tready = !in_valid_reg || fire;

    assign is_cal    = (in_user_reg[TU_CMD] == CMD_CAL);
    assign rd_ok     = in_user_reg[TU_OK];
    assign do_filter = !is_cal && rd_ok;
    assign cnt_inc   = cnt_reg + 1'b1;
    assign run_end   = (cnt_inc >= CNT_END);
    assign div_start = fire && is_cal && run_end;

    // per-axis reading: failed reads fall back to the last good one
    for (genvar i = 0; i < AXES; i++) begin : g_axis
        assign rd[i] = rd_ok ? signed'(in_data_reg[i*SMP_W +: SMP_W]) : last_reg[i];
        assign sum_add[i] = sum_reg[i] + SUM_W'(rd[i]);

        ioc_filter_lane #(
            .FRAC_BITS (FRAC_BITS)
        ) u_lane (
            .rd_i    (rd[i]),
            .ofs_i   (ofs[i]),
            .filt_i  (filt_reg[i]),
            .alpha_i (alpha_reg),
            .filt_o  (lane_filt[i])
        );

        assign filt_next[i] = do_filter ? lane_filt[i] : filt_reg[i];
    end

    ioc_offset_div #(
        .CAL_SAMPLES (CAL_SAMPLES),
        .FRAC_BITS   (FRAC_BITS)
    ) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start_i (div_start),
        .sum_i   (sum_add),
        .g_i     (g_reg),
        .busy_o  (div_busy),
        .ofs_o   (ofs)
    );

    always_comb begin
        if (is_cal) begin
            status_next = run_end ? STAT_CAL_DONE : STAT_CAL;
        end else if (rd_ok) begin
            status_next = STAT_OK;
        end else begin
            status_next = STAT_RD_FAIL;
        end
        out_data_next = '0;
        for (int i = 0; i < AXES; i++) begin
            out_data_next[i*OUT_W +: OUT_W] = OUT_W'(filt_next[i]);
        end
    end

    // config writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            alpha_reg <= ALPHA_RESET;
            g_reg     <= G_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                REG_ALPHA: alpha_reg <= cfg_wr_data[ALPHA_W-1:0];
                REG_G:     g_reg     <= cfg_wr_data[G_W-1:0];
                default: ;
            endcase
        end
    end

    // control and state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            cnt_reg       <= '0;
            for (int i = 0; i < AXES; i++) begin
                filt_reg[i] <= '0;
                sum_reg[i]  <= '0;
                last_reg[i] <= '0;
            end
        end else begin
            if (s_tvalid && s_tready) begin
                in_valid_reg <= 1'b1;
            end else if (fire) begin
                in_valid_reg <= 1'b0;
            end

            if (fire) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end

            if (fire) begin
                for (int i = 0; i < AXES; i++) begin
                    filt_reg[i] <= filt_next[i];
                    if (rd_ok) begin
                        last_reg[i] <= rd[i];
                    end
                    if (is_cal) begin
                        sum_reg[i] <= run_end ? '0 : sum_add[i];
                    end
                end
                if (is_cal) begin
                    cnt_reg <= run_end ? '0 : cnt_inc;
                end
            end
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_data_reg <= s_tdata;
            in_user_reg <= s_tuser;
        end
        if (fire) begin
            out_data_reg <= out_data_next;
            out_user_reg <= status_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;

endmodule
